@@ rtl/mab_pkg.sv @@
// Shared widths and constants for the mesh area and bounding box block.
package mab_pkg;

  localparam int COORD_W  = 16;             // Q8.8 vertex coordinate
  localparam int AREA_W   = 48;             // Q32.16 running area
  localparam int EMAG_W   = 16;             // magnitude of an edge component
  localparam int CROSS_W  = 35;             // signed cross product partial
  localparam int KMAG_W   = 34;             // magnitude of a cross component
  localparam int MUL_W    = 34;             // shared multiplier operand width
  localparam int SQ_W     = 2 * MUL_W;      // sum of squares
  localparam int ROOT_W   = SQ_W / 2;       // integer square root
  localparam int REM_W    = ROOT_W + 1;     // root remainder
  localparam int CNT_W    = 6;
  localparam int HALF_W   = ROOT_W - 1;

  // multiplier schedule: six cross terms, then three squares
  localparam int MUL_OPS  = 9;
  localparam int MUL_LAST = MUL_OPS;        // final consume step

  // edge component slots
  localparam int E_UX = 0;
  localparam int E_UY = 1;
  localparam int E_UZ = 2;
  localparam int E_VX = 3;
  localparam int E_VY = 4;
  localparam int E_VZ = 5;
  localparam int E_NUM = 6;

endpackage

@@ rtl/mesh_area_bounding_box_top.sv @@
// Mesh surface area and bounding box accumulator, top level.
// out_valid rises once the last triangle of a mesh has been accumulated.
// Triangles are taken one at a time: in_ready rises again only after the shared
// 34x34 multiplier (cross terms, then squares), the one-bit-per-cycle square root
// and an accumulate step, which for a last triangle waits while a result is held.
// Reset (rst_n low, synchronous): area cleared, box empty, no result pending.
module mesh_area_bounding_box_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [mab_pkg::COORD_W-1:0]   in_a_x,
  input  logic signed [mab_pkg::COORD_W-1:0]   in_a_y,
  input  logic signed [mab_pkg::COORD_W-1:0]   in_a_z,
  input  logic signed [mab_pkg::COORD_W-1:0]   in_b_x,
  input  logic signed [mab_pkg::COORD_W-1:0]   in_b_y,
  input  logic signed [mab_pkg::COORD_W-1:0]   in_b_z,
  input  logic signed [mab_pkg::COORD_W-1:0]   in_c_x,
  input  logic signed [mab_pkg::COORD_W-1:0]   in_c_y,
  input  logic signed [mab_pkg::COORD_W-1:0]   in_c_z,
  input  logic                                 in_last_triangle,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [mab_pkg::AREA_W-1:0]    out_area_total,
  output logic signed [mab_pkg::COORD_W-1:0]   out_min_x,
  output logic signed [mab_pkg::COORD_W-1:0]   out_min_y,
  output logic signed [mab_pkg::COORD_W-1:0]   out_min_z,
  output logic signed [mab_pkg::COORD_W-1:0]   out_max_x,
  output logic signed [mab_pkg::COORD_W-1:0]   out_max_y,
  output logic signed [mab_pkg::COORD_W-1:0]   out_max_z,
  output logic        [mab_pkg::COORD_W-1:0]   out_span_length
);
  import mab_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_SQRT, ST_FIN} state_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  state_t               state_r;
  logic [CNT_W-1:0]     cnt_r;

  coord_t               ax_r, ay_r, az_r, bx_r, by_r, bz_r, cx_r, cy_r, cz_r;
  logic                 last_r;
  logic [EMAG_W-1:0]    emag_r [E_NUM];
  logic [E_NUM-1:0]     eneg_r;

  logic [SQ_W-1:0]      prod_r;
  logic                 pneg_r;
  logic signed [CROSS_W-1:0] term_r;
  logic [KMAG_W-1:0]    kx_r, ky_r, kz_r;
  logic [SQ_W-1:0]      sq_r;
  logic [REM_W-1:0]     rem_r;
  logic [ROOT_W-1:0]    root_r;

  logic [AREA_W-1:0]    sum_area_r;
  coord_t               low_x_r, low_y_r, low_z_r, high_x_r, high_y_r, high_z_r;
  logic                 box_empty_r;

  logic                 out_valid_r;
  logic [AREA_W-1:0]    out_area_r;
  coord_t               out_min_x_r, out_min_y_r, out_min_z_r;
  coord_t               out_max_x_r, out_max_y_r, out_max_z_r;
  logic [COORD_W-1:0]   out_span_r;

  function automatic coord_t smin(coord_t p, coord_t q);
    return (q < p) ? q : p;
  endfunction

  function automatic coord_t smax(coord_t p, coord_t q);
    return (q > p) ? q : p;
  endfunction

  // edges at the input, as magnitude and sign
  logic signed [COORD_W:0] edge_d [E_NUM];
  always_comb begin
    edge_d[E_UX] = {in_b_x[COORD_W-1], in_b_x} - {in_a_x[COORD_W-1], in_a_x};
    edge_d[E_UY] = {in_b_y[COORD_W-1], in_b_y} - {in_a_y[COORD_W-1], in_a_y};
    edge_d[E_UZ] = {in_b_z[COORD_W-1], in_b_z} - {in_a_z[COORD_W-1], in_a_z};
    edge_d[E_VX] = {in_c_x[COORD_W-1], in_c_x} - {in_a_x[COORD_W-1], in_a_x};
    edge_d[E_VY] = {in_c_y[COORD_W-1], in_c_y} - {in_a_y[COORD_W-1], in_a_y};
    edge_d[E_VZ] = {in_c_z[COORD_W-1], in_c_z} - {in_a_z[COORD_W-1], in_a_z};
  end

  // shared multiplier operand select
  logic [MUL_W-1:0] mul_a, mul_b;
  logic             mul_neg;
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (cnt_r)
      CNT_W'(0): begin
        mul_a = MUL_W'(emag_r[E_UY]); mul_b = MUL_W'(emag_r[E_VZ]);
        mul_neg = eneg_r[E_UY] ^ eneg_r[E_VZ];
      end
      CNT_W'(1): begin
        mul_a = MUL_W'(emag_r[E_UZ]); mul_b = MUL_W'(emag_r[E_VY]);
        mul_neg = eneg_r[E_UZ] ^ eneg_r[E_VY];
      end
      CNT_W'(2): begin
        mul_a = MUL_W'(emag_r[E_UZ]); mul_b = MUL_W'(emag_r[E_VX]);
        mul_neg = eneg_r[E_UZ] ^ eneg_r[E_VX];
      end
      CNT_W'(3): begin
        mul_a = MUL_W'(emag_r[E_UX]); mul_b = MUL_W'(emag_r[E_VZ]);
        mul_neg = eneg_r[E_UX] ^ eneg_r[E_VZ];
      end
      CNT_W'(4): begin
        mul_a = MUL_W'(emag_r[E_UX]); mul_b = MUL_W'(emag_r[E_VY]);
        mul_neg = eneg_r[E_UX] ^ eneg_r[E_VY];
      end
      CNT_W'(5): begin
        mul_a = MUL_W'(emag_r[E_UY]); mul_b = MUL_W'(emag_r[E_VX]);
        mul_neg = eneg_r[E_UY] ^ eneg_r[E_VX];
      end
      CNT_W'(6): begin mul_a = kx_r; mul_b = kx_r; end
      CNT_W'(7): begin mul_a = ky_r; mul_b = ky_r; end
      CNT_W'(8): begin mul_a = kz_r; mul_b = kz_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // consume side: signed cross term and difference magnitude
  logic signed [CROSS_W-1:0] prod_s, cross_d;
  logic [KMAG_W-1:0]         cross_mag;
  always_comb begin
    prod_s    = $signed({1'b0, prod_r[CROSS_W-2:0]});
    if (pneg_r) prod_s = -prod_s;
    cross_d   = term_r - prod_s;
    cross_mag = cross_d[CROSS_W-1] ? KMAG_W'(-cross_d) : KMAG_W'(cross_d);
  end

  // square root step: two radicand bits per cycle
  logic [REM_W+1:0] rem_t, trial;
  logic             root_bit;
  logic [REM_W+1:0] rem_diff;
  always_comb begin
    rem_t    = {rem_r, sq_r[SQ_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    root_bit = (rem_t >= trial);
    rem_diff = rem_t - trial;
  end

  // accumulate and box update
  logic [HALF_W-1:0]   half_area;
  logic [AREA_W:0]     area_sum;
  logic [AREA_W-1:0]   area_new;
  coord_t              lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic signed [COORD_W:0] span_x, span_z;
  logic [COORD_W-1:0]  span;
  logic                fin_go;
  always_comb begin
    half_area = root_r[ROOT_W-1:1];
    area_sum  = {1'b0, sum_area_r} + (AREA_W+1)'(half_area);
    area_new  = area_sum[AREA_W] ? {AREA_W{1'b1}} : area_sum[AREA_W-1:0];
    lo_x = smin(smin(smin(box_empty_r ? ax_r : low_x_r, ax_r), bx_r), cx_r);
    lo_y = smin(smin(smin(box_empty_r ? ay_r : low_y_r, ay_r), by_r), cy_r);
    lo_z = smin(smin(smin(box_empty_r ? az_r : low_z_r, az_r), bz_r), cz_r);
    hi_x = smax(smax(smax(box_empty_r ? ax_r : high_x_r, ax_r), bx_r), cx_r);
    hi_y = smax(smax(smax(box_empty_r ? ay_r : high_y_r, ay_r), by_r), cy_r);
    hi_z = smax(smax(smax(box_empty_r ? az_r : high_z_r, az_r), bz_r), cz_r);
    span_x = {hi_x[COORD_W-1], hi_x} - {lo_x[COORD_W-1], lo_x};
    span_z = {hi_z[COORD_W-1], hi_z} - {lo_z[COORD_W-1], lo_z};
    span   = (span_x > span_z) ? span_x[COORD_W-1:0] : span_z[COORD_W-1:0];
    // a last triangle waits here while the previous result is still held
    fin_go = !last_r || !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      sum_area_r  <= '0;
      box_empty_r <= 1'b1;
      low_x_r     <= '0;
      low_y_r     <= '0;
      low_z_r     <= '0;
      high_x_r    <= '0;
      high_y_r    <= '0;
      high_z_r    <= '0;
    end else begin
      // a new result loaded in the same cycle takes over the held one
      if (out_valid_r && out_ready && !(state_r == ST_FIN && last_r)) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            ax_r <= in_a_x; ay_r <= in_a_y; az_r <= in_a_z;
            bx_r <= in_b_x; by_r <= in_b_y; bz_r <= in_b_z;
            cx_r <= in_c_x; cy_r <= in_c_y; cz_r <= in_c_z;
            last_r <= in_last_triangle;
            for (int i = 0; i < E_NUM; i++) begin
              eneg_r[i] <= edge_d[i][COORD_W];
              emag_r[i] <= edge_d[i][COORD_W] ? EMAG_W'(-edge_d[i])
                                              : EMAG_W'(edge_d[i]);
            end
            sq_r    <= '0;
            cnt_r   <= '0;
            state_r <= ST_MUL;
          end
        end

        ST_MUL: begin
          // issue op cnt, consume the product of op cnt-1
          prod_r <= mul_a * mul_b;
          pneg_r <= mul_neg;
          case (cnt_r)
            CNT_W'(1), CNT_W'(3), CNT_W'(5): term_r <= prod_s;
            CNT_W'(2): kx_r <= cross_mag;
            CNT_W'(4): ky_r <= cross_mag;
            CNT_W'(6): kz_r <= cross_mag;
            CNT_W'(7), CNT_W'(8), CNT_W'(9): sq_r <= sq_r + prod_r;
            default: ;
          endcase
          if (cnt_r == CNT_W'(MUL_LAST)) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            root_r  <= '0;
            state_r <= ST_SQRT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        ST_SQRT: begin
          rem_r  <= root_bit ? rem_diff[REM_W-1:0] : rem_t[REM_W-1:0];
          root_r <= {root_r[ROOT_W-2:0], root_bit};
          sq_r   <= {sq_r[SQ_W-3:0], 2'b00};
          if (cnt_r == CNT_W'(ROOT_W - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_FIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        ST_FIN: begin
          if (fin_go) begin
            state_r <= ST_IDLE;
            if (last_r) begin
              out_valid_r <= 1'b1;
              out_area_r  <= area_new;
              out_min_x_r <= lo_x; out_min_y_r <= lo_y; out_min_z_r <= lo_z;
              out_max_x_r <= hi_x; out_max_y_r <= hi_y; out_max_z_r <= hi_z;
              out_span_r  <= span;
              sum_area_r  <= '0;
              box_empty_r <= 1'b1;
              low_x_r <= '0; low_y_r <= '0; low_z_r <= '0;
              high_x_r <= '0; high_y_r <= '0; high_z_r <= '0;
            end else begin
              sum_area_r  <= area_new;
              box_empty_r <= 1'b0;
              low_x_r <= lo_x; low_y_r <= lo_y; low_z_r <= lo_z;
              high_x_r <= hi_x; high_y_r <= hi_y; high_z_r <= hi_z;
            end
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_area_total  = out_area_r;
  assign out_min_x       = out_min_x_r;
  assign out_min_y       = out_min_y_r;
  assign out_min_z       = out_min_z_r;
  assign out_max_x       = out_max_x_r;
  assign out_max_y       = out_max_y_r;
  assign out_max_z       = out_max_z_r;
  assign out_span_length = out_span_r;

endmodule

@@ test/mesh_area_bounding_box_top_tb.sv @@
// Self-checking testbench for the mesh area and bounding box block.
module mesh_area_bounding_box_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mab_pkg::*;

  localparam int HOLD_CYCLES  = 600;      // long receiver hold-off
  localparam int DRAIN_CYCLES = 60;       // idle run-out before the final verdict
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 412;
  localparam logic [63:0] AREA_MAX = 64'h0000_FFFF_FFFF_FFFF;

  localparam logic signed [COORD_W-1:0] C_ZERO = 16'sh0000;
  localparam logic signed [COORD_W-1:0] C_ONE  = 16'sh0100;  // 1.0 in Q8.8
  localparam logic signed [COORD_W-1:0] C_MIN  = 16'sh8000;
  localparam logic signed [COORD_W-1:0] C_MAX  = 16'sh7FFF;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x, a_y, a_z;
    logic signed [COORD_W-1:0] b_x, b_y, b_z;
    logic signed [COORD_W-1:0] c_x, c_y, c_z;
    logic                      last;
  } triangle_t;

  typedef struct packed {
    logic [AREA_W-1:0]  area;
    logic [COORD_W-1:0] min_x, min_y, min_z;
    logic [COORD_W-1:0] max_x, max_y, max_z;
    logic [COORD_W-1:0] span;
  } mesh_summary_t;

  typedef struct packed {
    triangle_t     shape;
    logic          typed;   // expected summary written out by hand
    mesh_summary_t want;
  } stim_row_t;

  localparam mesh_summary_t NO_SUMMARY = '0;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [COORD_W-1:0] in_a_x, in_a_y, in_a_z;
  logic signed [COORD_W-1:0] in_b_x, in_b_y, in_b_z;
  logic signed [COORD_W-1:0] in_c_x, in_c_y, in_c_z;
  logic in_last_triangle;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [AREA_W-1:0] out_area_total;
  logic signed [COORD_W-1:0] out_min_x, out_min_y, out_min_z;
  logic signed [COORD_W-1:0] out_max_x, out_max_y, out_max_z;
  logic [COORD_W-1:0] out_span_length;

  mesh_summary_t mesh_results_due[$];
  stim_row_t     dir_rows[$];
  int fail_count  = 0;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_asked  = 0;
  int hold_taken  = 0;
  int hold_left   = 0;

  // predictor state for the mesh being collected
  logic [63:0] area_acc;
  longint lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  bit box_blank;

  mesh_area_bounding_box_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_a_x           (in_a_x),
    .in_a_y           (in_a_y),
    .in_a_z           (in_a_z),
    .in_b_x           (in_b_x),
    .in_b_y           (in_b_y),
    .in_b_z           (in_b_z),
    .in_c_x           (in_c_x),
    .in_c_y           (in_c_y),
    .in_c_z           (in_c_z),
    .in_last_triangle (in_last_triangle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_area_total   (out_area_total),
    .out_min_x        (out_min_x),
    .out_min_y        (out_min_y),
    .out_min_z        (out_min_z),
    .out_max_x        (out_max_x),
    .out_max_y        (out_max_y),
    .out_max_z        (out_max_z),
    .out_span_length  (out_span_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void clear_mesh();
    area_acc  = '0;
    lo_x = 0; lo_y = 0; lo_z = 0;
    hi_x = 0; hi_y = 0; hi_z = 0;
    box_blank = 1'b1;
  endfunction

  function automatic void widen_box(longint x, longint y, longint z);
    if (x < lo_x) lo_x = x;
    if (x > hi_x) hi_x = x;
    if (y < lo_y) lo_y = y;
    if (y > hi_y) hi_y = y;
    if (z < lo_z) lo_z = z;
    if (z > hi_z) hi_z = z;
  endfunction

  function automatic void expect_summary(mesh_summary_t s);
    mesh_results_due.insert(mesh_results_due.size(), s);
  endfunction

  function automatic void add_row(stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // Folds one triangle into the running mesh; returns 1 with the summary on
  // the last triangle of a mesh.
  function automatic bit accumulate_triangle(input triangle_t t, output mesh_summary_t s);
    longint ax, ay, az, bx, by, bz, cx, cy, cz;
    longint ux, uy, uz, vx, vy, vz, nx, ny, nz, sx, sz;
    logic [127:0] kx, ky, kz, sq, root, trial;
    s  = NO_SUMMARY;
    ax = $signed(t.a_x); ay = $signed(t.a_y); az = $signed(t.a_z);
    bx = $signed(t.b_x); by = $signed(t.b_y); bz = $signed(t.b_z);
    cx = $signed(t.c_x); cy = $signed(t.c_y); cz = $signed(t.c_z);
    ux = bx - ax; uy = by - ay; uz = bz - az;
    vx = cx - ax; vy = cy - ay; vz = cz - az;
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    kx = (nx < 0) ? -nx : nx;
    ky = (ny < 0) ? -ny : ny;
    kz = (nz < 0) ? -nz : nz;
    sq = kx * kx + ky * ky + kz * kz;
    // floor square root, one bit at a time from the top
    root = '0;
    for (int b = 34; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    root = root >> 1;
    area_acc = area_acc + root[63:0];
    if (area_acc > AREA_MAX) area_acc = AREA_MAX;
    if (box_blank) begin
      lo_x = ax; hi_x = ax;
      lo_y = ay; hi_y = ay;
      lo_z = az; hi_z = az;
      box_blank = 1'b0;
    end
    widen_box(ax, ay, az);
    widen_box(bx, by, bz);
    widen_box(cx, cy, cz);
    if (!t.last) return 1'b0;
    sx = hi_x - lo_x;
    sz = hi_z - lo_z;
    s.area  = area_acc[AREA_W-1:0];
    s.min_x = COORD_W'(lo_x);
    s.min_y = COORD_W'(lo_y);
    s.min_z = COORD_W'(lo_z);
    s.max_x = COORD_W'(hi_x);
    s.max_y = COORD_W'(hi_y);
    s.max_z = COORD_W'(hi_z);
    s.span  = COORD_W'((sx > sz) ? sx : sz);
    clear_mesh();
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // result side: checks each transfer, then decides the next ready
  always @(posedge clk) begin : result_side
    mesh_summary_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (mesh_results_due.size() == 0) begin
          $error("result with no mesh outstanding: area_total %0h", out_area_total);
          fail_count++;
        end else begin
          want = mesh_results_due.pop_front();
          check_field("area_total",  want.area,  out_area_total);
          check_field("min_x",       want.min_x, $unsigned(out_min_x));
          check_field("min_y",       want.min_y, $unsigned(out_min_y));
          check_field("min_z",       want.min_z, $unsigned(out_min_z));
          check_field("max_x",       want.max_x, $unsigned(out_max_x));
          check_field("max_y",       want.max_y, $unsigned(out_max_y));
          check_field("max_z",       want.max_z, $unsigned(out_max_z));
          check_field("span_length", want.span,  out_span_length);
        end
      end
      if (hold_taken != hold_asked) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = hold_asked;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_triangle(input triangle_t t, input bit typed,
                               input mesh_summary_t typed_want);
    mesh_summary_t s;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_a_x           <= t.a_x;
    in_a_y           <= t.a_y;
    in_a_z           <= t.a_z;
    in_b_x           <= t.b_x;
    in_b_y           <= t.b_y;
    in_b_z           <= t.b_z;
    in_c_x           <= t.c_x;
    in_c_y           <= t.c_y;
    in_c_z           <= t.c_z;
    in_last_triangle <= t.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (accumulate_triangle(t, s)) expect_summary(typed ? typed_want : s);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (mesh_results_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] any_coord();
    return COORD_W'($urandom());
  endfunction

  // small signed step in [-512, 512]
  function automatic logic signed [COORD_W-1:0] near_step();
    return COORD_W'($urandom_range(1024)) - 16'sd512;
  endfunction

  function automatic triangle_t random_triangle();
    triangle_t t;
    int kind;
    logic signed [COORD_W-1:0] dx, dy, dz;
    kind = $urandom_range(99);
    t.a_x = any_coord(); t.a_y = any_coord(); t.a_z = any_coord();
    t.last = 1'b0;
    if (kind < 55) begin
      t.b_x = any_coord(); t.b_y = any_coord(); t.b_z = any_coord();
      t.c_x = any_coord(); t.c_y = any_coord(); t.c_z = any_coord();
    end else if (kind < 85) begin
      t.b_x = t.a_x + near_step(); t.b_y = t.a_y + near_step(); t.b_z = t.a_z + near_step();
      t.c_x = t.a_x + near_step(); t.c_y = t.a_y + near_step(); t.c_z = t.a_z + near_step();
    end else begin
      // degenerate: repeated vertex or three points on a line
      dx = near_step(); dy = near_step(); dz = near_step();
      t.b_x = t.a_x + dx; t.b_y = t.a_y + dy; t.b_z = t.a_z + dz;
      t.c_x = t.b_x + dx; t.c_y = t.b_y + dy; t.c_z = t.b_z + dz;
      case ($urandom_range(2))
        0: begin
          t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
        end
        1: begin
          t.c_x = t.b_x; t.c_y = t.b_y; t.c_z = t.b_z;
        end
        default: ;
      endcase
    end
    return t;
  endfunction

  initial begin
    int fed;
    int mesh_len;
    int pick;
    triangle_t t;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_a_x = '0; in_a_y = '0; in_a_z = '0;
    in_b_x = '0; in_b_y = '0; in_b_z = '0;
    in_c_x = '0; in_c_y = '0; in_c_z = '0;
    in_last_triangle = 1'b0;
    clear_mesh();

    // straight after reset: all-zero triangle
    add_row('{'{C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
                C_ZERO, C_ZERO, C_ZERO, 1'b1}, 1'b1,
              '{48'h0, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 16'h0}});
    // one point at the most negative corner
    add_row('{'{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                C_MIN, C_MIN, C_MIN, 1'b1}, 1'b1,
              '{48'h0, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 16'h0}});
    // zero area, but the box spans the whole range
    add_row('{'{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                C_MAX, C_MAX, C_MAX, 1'b1}, 1'b1,
              '{48'h0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 16'hFFFF}});
    // unit right triangle: area one half
    add_row('{'{C_ZERO, C_ZERO, C_ZERO, C_ONE, C_ZERO, C_ZERO,
                C_ZERO, C_ONE, C_ZERO, 1'b1}, 1'b1,
              '{48'h8000, C_ZERO, C_ZERO, C_ZERO, C_ONE, C_ONE, C_ZERO, 16'h0100}});
    // two of them in one mesh
    add_row('{'{C_ZERO, C_ZERO, C_ZERO, C_ONE, C_ZERO, C_ZERO,
                C_ZERO, C_ONE, C_ZERO, 1'b0}, 1'b0, NO_SUMMARY});
    add_row('{'{C_ZERO, C_ZERO, C_ZERO, C_ONE, C_ZERO, C_ZERO,
                C_ZERO, C_ONE, C_ZERO, 1'b1}, 1'b1,
              '{48'h10000, C_ZERO, C_ZERO, C_ZERO, C_ONE, C_ONE, C_ZERO, 16'h0100}});
    // opposite winding gives the same area
    add_row('{'{C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ONE, C_ZERO,
                C_ONE, C_ZERO, C_ZERO, 1'b1}, 1'b1,
              '{48'h8000, C_ZERO, C_ZERO, C_ZERO, C_ONE, C_ONE, C_ZERO, 16'h0100}});
    // box away from the origin: must not keep the cleared zeros
    add_row('{'{16'sh0200, 16'sh0300, 16'sh0400, 16'sh0400, 16'sh0300, 16'sh0200,
                16'sh0300, 16'sh0400, 16'sh0300, 1'b0}, 1'b0, NO_SUMMARY});
    add_row('{'{16'sh0280, 16'sh0380, 16'sh0300, 16'sh0290, 16'sh03A0, 16'sh0310,
                16'sh02F0, 16'sh0350, 16'sh0330, 1'b1}, 1'b0, NO_SUMMARY});
    // largest cross product
    add_row('{'{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                C_MAX, C_MIN, C_MAX, 1'b1}, 1'b0, NO_SUMMARY});
    // z span wider than x span
    add_row('{'{C_ZERO, C_ZERO, 16'shFC18, 16'sh000A, C_ZERO, 16'sh03E8,
                C_ZERO, 16'sh0005, C_ZERO, 1'b1}, 1'b0, NO_SUMMARY});
    // collinear, then a single point
    add_row('{'{C_ZERO, C_ZERO, C_ZERO, C_ONE, C_ONE, C_ONE,
                16'sh0200, 16'sh0200, 16'sh0200, 1'b0}, 1'b0, NO_SUMMARY});
    add_row('{'{16'shFF00, C_ZERO, C_ZERO, 16'shFF00, C_ZERO, C_ZERO,
                16'shFF00, C_ZERO, C_ZERO, 1'b1}, 1'b0, NO_SUMMARY});
    // alternating extremes
    add_row('{'{C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN,
                C_ZERO, C_ZERO, C_ZERO, 1'b0}, 1'b0, NO_SUMMARY});
    add_row('{'{16'sh0001, 16'shFFFF, 16'sh4000, 16'shC000, 16'sh0001, 16'shFFFF,
                16'sh1234, 16'shEDCB, C_ZERO, 1'b1}, 1'b0, NO_SUMMARY});
    // sliver whose half length truncates to zero
    add_row('{'{C_ZERO, C_ZERO, C_ZERO, 16'sh0001, C_ZERO, C_ZERO,
                C_MAX, 16'sh0001, C_ZERO, 1'b1}, 1'b0, NO_SUMMARY});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_triangle(dir_rows[i].shape, dir_rows[i].typed, dir_rows[i].want);
    wait_results_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      // receiver holds off while triangles keep coming, so the input backs up
      if (p == 0) hold_asked++;
      fed = 0;
      while (fed < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 30)      mesh_len = 1;
        else if (pick < 90) mesh_len = $urandom_range(8, 2);
        else                mesh_len = $urandom_range(40, 9);
        for (int k = 0; k < mesh_len; k++) begin
          t      = random_triangle();
          t.last = (k == mesh_len - 1);
          send_triangle(t, 1'b0, NO_SUMMARY);
          fed++;
        end
      end
      wait_results_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && mesh_results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mab_pkg.sv
rtl/mesh_area_bounding_box_top.sv
test/mesh_area_bounding_box_top_tb.sv
